>>> hw/rtl/pewr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pewr_pkg
// Shared types and constants for the packed entry width repacker.
// ----------------------------------------------------------------------------
package pewr_pkg;

   localparam int WORD_BITS  = 64;
   localparam int WIDTH_W    = 7;
   localparam int TOTAL_W    = 13;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;

   localparam logic [REG_IDX_W-1:0] REG_IN_WIDTH    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_OUT_WIDTH   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_ENTRY_TOTAL = 2'd2;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET = 7'd4;
   localparam logic [TOTAL_W-1:0] TOTAL_RESET = 13'd0;

   typedef struct packed {
      logic [WIDTH_W-1:0] in_width;     // clamped to 1..64
      logic [WIDTH_W-1:0] out_width;    // clamped to 1..64
      logic [TOTAL_W-1:0] entry_total;  // raw register value
   } cfg_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] lo;
      logic [WORD_BITS-1:0] hi;
      logic [WIDTH_W-1:0]   avail;
      logic [WORD_BITS-1:0] build_word;
      logic [WIDTH_W-1:0]   build_fill;
   } step_in_type;

   typedef struct packed {
      logic                 entry_ok;   // enough bits for one more entry
      logic                 emit;       // this entry completes a word
      logic                 exact;      // the word completes exactly at 64 bits
      logic [WORD_BITS-1:0] word_out;
      logic [WORD_BITS-1:0] lo;
      logic [WORD_BITS-1:0] hi;
      logic [WIDTH_W-1:0]   avail;
      logic [WORD_BITS-1:0] build_word;
      logic [WIDTH_W-1:0]   build_fill;
   } step_out_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ENTRY = 3'b010,
      ST_FINAL = 3'b100
   } state_type;

endpackage
`default_nettype wire

>>> hw/rtl/pewr_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pewr_csr
// Configuration registers behind the APB-style port, with width clamping.
// ----------------------------------------------------------------------------
module pewr_csr (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pewr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pewr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [pewr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready,
   output pewr_pkg::cfg_type                    cfg
);

   logic [pewr_pkg::WIDTH_W-1:0]   in_width_ff, in_width_in;
   logic [pewr_pkg::WIDTH_W-1:0]   out_width_ff, out_width_in;
   logic [pewr_pkg::TOTAL_W-1:0]   entry_total_ff, entry_total_in;
   logic [pewr_pkg::REG_IDX_W-1:0] reg_idx;
   logic                           wr_en;

   assign reg_idx    = csr_paddr[pewr_pkg::CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      in_width_in    = in_width_ff;
      out_width_in   = out_width_ff;
      entry_total_in = entry_total_ff;
      if (wr_en) begin
         unique case (reg_idx)
            pewr_pkg::REG_IN_WIDTH:    in_width_in    = csr_pwdata[pewr_pkg::WIDTH_W-1:0];
            pewr_pkg::REG_OUT_WIDTH:   out_width_in   = csr_pwdata[pewr_pkg::WIDTH_W-1:0];
            pewr_pkg::REG_ENTRY_TOTAL: entry_total_in = csr_pwdata[pewr_pkg::TOTAL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_width_ff    <= pewr_pkg::WIDTH_RESET;
         out_width_ff   <= pewr_pkg::WIDTH_RESET;
         entry_total_ff <= pewr_pkg::TOTAL_RESET;
      end else begin
         in_width_ff    <= in_width_in;
         out_width_ff   <= out_width_in;
         entry_total_ff <= entry_total_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         pewr_pkg::REG_IN_WIDTH:
            csr_prdata = pewr_pkg::CSR_DATA_W'(in_width_ff);
         pewr_pkg::REG_OUT_WIDTH:
            csr_prdata = pewr_pkg::CSR_DATA_W'(out_width_ff);
         pewr_pkg::REG_ENTRY_TOTAL:
            csr_prdata = pewr_pkg::CSR_DATA_W'(entry_total_ff);
         default:
            csr_prdata = '0;
      endcase
   end

   function automatic logic [pewr_pkg::WIDTH_W-1:0] clamp_width(
      input logic [pewr_pkg::WIDTH_W-1:0] w
   );
      logic [pewr_pkg::WIDTH_W-1:0] r;
      r = w;
      if (w == '0) begin
         r = 7'd1;
      end else if (w > 7'd64) begin
         r = 7'd64;
      end
      return r;
   endfunction

   assign cfg.in_width    = clamp_width(in_width_ff);
   assign cfg.out_width   = clamp_width(out_width_ff);
   assign cfg.entry_total = entry_total_ff;

endmodule
`default_nettype wire

>>> hw/rtl/pewr_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pewr_step_unit
// Shared shift unit: extracts one entry from the input window and packs it
// into the output word under construction.
// ----------------------------------------------------------------------------
module pewr_step_unit (
   input  wire logic [pewr_pkg::WIDTH_W-1:0] in_width,
   input  wire logic [pewr_pkg::WIDTH_W-1:0] out_width,
   input  wire pewr_pkg::step_in_type        step_in,
   output pewr_pkg::step_out_type            step_out
);

   localparam int DW = 2 * pewr_pkg::WORD_BITS;

   logic [pewr_pkg::WORD_BITS-1:0] imask;
   logic [pewr_pkg::WORD_BITS-1:0] omask;
   logic [pewr_pkg::WORD_BITS-1:0] entry_val;
   logic [DW-1:0]                  window_shr;
   logic [DW-1:0]                  placed;
   logic [pewr_pkg::WIDTH_W-1:0]   fill_sum;
   logic [pewr_pkg::WORD_BITS-1:0] merged;

   assign imask = {pewr_pkg::WORD_BITS{1'b1}} >> (7'd64 - in_width);
   assign omask = {pewr_pkg::WORD_BITS{1'b1}} >> (7'd64 - out_width);

   assign entry_val  = step_in.lo & imask & omask;
   assign window_shr = {step_in.hi, step_in.lo} >> in_width;
   assign placed     = {{pewr_pkg::WORD_BITS{1'b0}}, entry_val} << step_in.build_fill[5:0];
   assign fill_sum   = {1'b0, step_in.build_fill[5:0]} + out_width;
   assign merged     = step_in.build_word | placed[pewr_pkg::WORD_BITS-1:0];

   always_comb begin
      step_out.entry_ok = (step_in.avail >= in_width);
      step_out.emit     = fill_sum[6];
      step_out.exact    = (fill_sum == 7'd64);
      step_out.word_out = merged;
      step_out.lo       = window_shr[pewr_pkg::WORD_BITS-1:0];
      step_out.hi       = window_shr[DW-1:pewr_pkg::WORD_BITS];
      step_out.avail    = step_in.avail - in_width;
      if (fill_sum[6]) begin
         step_out.build_word = placed[DW-1:pewr_pkg::WORD_BITS];
         step_out.build_fill = {1'b0, fill_sum[5:0]};
      end else begin
         step_out.build_word = merged;
         step_out.build_fill = fill_sum;
      end
   end

endmodule
`default_nettype wire

>>> hw/rtl/packed_entry_width_repacker_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// packed_entry_width_repacker_top
// Repacks a stream of packed fixed-width entries into a new entry width.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries 64-bit input words, entries of in_width bits packed LSB
//   first. rsp_* carries 64-bit output words of out_width entries; frame_end
//   marks the last word of a frame of entry_total entries. Program in_width,
//   out_width and entry_total through csr_* while the block is idle.
//   Each input word is taken in ST_IDLE; the block then extracts one entry
//   per cycle with its single shift unit, unless waiting on the output
//   register. After the last entry of a word, an ENTRY step finds the word
//   used up, or ST_FINAL flushes the frame at its end; req_stall stays high
//   until the block is back in ST_IDLE. An output word is registered and
//   presented in the cycle after the entry that completes it.
//   The output register holds a word while rsp_stall is high; the sequencer
//   waits whenever it needs to emit into a still occupied register.
//   Reset restores widths of 4, an entry count of 0 and an empty frame.
// ----------------------------------------------------------------------------
module packed_entry_width_repacker_top #(
   parameter int MAX_ENTRIES = 4096
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [63:0]                     req_packed_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [63:0]                     rsp_packed_out,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [pewr_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [pewr_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic      [pewr_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                                 csr_pready
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W = (CNT_W > pewr_pkg::TOTAL_W) ? CNT_W : pewr_pkg::TOTAL_W;
   localparam int WB    = pewr_pkg::WORD_BITS;
   localparam int WW    = pewr_pkg::WIDTH_W;

   pewr_pkg::cfg_type      cfg;
   pewr_pkg::step_in_type  step_in;
   pewr_pkg::step_out_type step_out;

   pewr_pkg::state_type state_ff, state_in;
   logic [WB-1:0]    lo_ff, lo_in;
   logic [WB-1:0]    hi_ff, hi_in;
   logic [WW-1:0]    avail_ff, avail_in;
   logic [WB-1:0]    build_word_ff, build_word_in;
   logic [WW-1:0]    build_fill_ff, build_fill_in;
   logic [CNT_W-1:0] entries_done_ff, entries_done_in;
   logic [WW-1:0]    emit_cnt_ff, emit_cnt_in;
   logic             force_ff, force_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WB-1:0]    rsp_packed_out_ff, rsp_packed_out_in;
   logic             rsp_frame_end_ff, rsp_frame_end_in;

   logic [EXT_W-1:0] total_ext;
   logic [CNT_W-1:0] total;
   logic             frame_over;
   logic             last_entry;
   logic             out_free;
   logic             req_take;
   logic [2*WB-1:0]  load_window;
   logic [5:0]       carry_cnt;
   logic             final_emit;

   pewr_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   assign step_in.lo         = lo_ff;
   assign step_in.hi         = hi_ff;
   assign step_in.avail      = avail_ff;
   assign step_in.build_word = build_word_ff;
   assign step_in.build_fill = build_fill_ff;

   pewr_step_unit u_step (
      .in_width  (cfg.in_width),
      .out_width (cfg.out_width),
      .step_in   (step_in),
      .step_out  (step_out)
   );

   assign total_ext  = EXT_W'(cfg.entry_total);
   assign total      = (total_ext > EXT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES)
                                                         : CNT_W'(total_ext);
   assign frame_over = (entries_done_ff != '0) && (entries_done_ff >= total);
   assign last_entry = (({1'b0, entries_done_ff} + 1'b1) >= {1'b0, total});
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign req_stall  = (state_ff != pewr_pkg::ST_IDLE);
   assign req_take   = req_valid && !req_stall;

   assign carry_cnt   = avail_ff[5:0];
   assign load_window = ({{WB{1'b0}}, req_packed_in} << carry_cnt) | {{WB{1'b0}}, lo_ff};
   assign final_emit  = force_ff || ((build_fill_ff != '0) && !emit_cnt_ff[6]);

   always_comb begin
      state_in          = state_ff;
      lo_in             = lo_ff;
      hi_in             = hi_ff;
      avail_in          = avail_ff;
      build_word_in     = build_word_ff;
      build_fill_in     = build_fill_ff;
      entries_done_in   = entries_done_ff;
      emit_cnt_in       = emit_cnt_ff;
      force_in          = force_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_packed_out_in = rsp_packed_out_ff;
      rsp_frame_end_in  = rsp_frame_end_ff;

      unique case (state_ff)
         pewr_pkg::ST_IDLE: begin
            if (req_take) begin
               emit_cnt_in = '0;
               if (frame_over) begin
                  force_in = 1'b1;
                  state_in = pewr_pkg::ST_FINAL;
               end else if (total != '0) begin
                  lo_in    = load_window[WB-1:0];
                  hi_in    = load_window[2*WB-1:WB];
                  avail_in = {1'b0, carry_cnt} + 7'd64;
                  force_in = 1'b0;
                  state_in = pewr_pkg::ST_ENTRY;
               end
            end
         end

         pewr_pkg::ST_ENTRY: begin
            if (!step_out.entry_ok || emit_cnt_ff[6]) begin
               state_in = pewr_pkg::ST_IDLE;
            end else if (!step_out.emit || out_free) begin
               lo_in           = step_out.lo;
               hi_in           = step_out.hi;
               avail_in        = step_out.avail;
               build_word_in   = step_out.build_word;
               build_fill_in   = step_out.build_fill;
               entries_done_in = entries_done_ff + 1'b1;
               if (step_out.emit) begin
                  rsp_valid_in      = 1'b1;
                  rsp_packed_out_in = step_out.word_out;
                  rsp_frame_end_in  = last_entry && step_out.exact;
                  emit_cnt_in       = emit_cnt_ff + 1'b1;
               end
               if (last_entry) begin
                  state_in = pewr_pkg::ST_FINAL;
               end
            end
         end

         pewr_pkg::ST_FINAL: begin
            if (!final_emit || out_free) begin
               if (final_emit) begin
                  rsp_valid_in      = 1'b1;
                  rsp_packed_out_in = build_word_ff;
                  rsp_frame_end_in  = 1'b1;
               end
               lo_in           = '0;
               hi_in           = '0;
               avail_in        = '0;
               build_word_in   = '0;
               build_fill_in   = '0;
               entries_done_in = '0;
               force_in        = 1'b0;
               state_in        = pewr_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = pewr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= pewr_pkg::ST_IDLE;
         lo_ff            <= '0;
         hi_ff            <= '0;
         avail_ff         <= '0;
         build_word_ff    <= '0;
         build_fill_ff    <= '0;
         entries_done_ff  <= '0;
         emit_cnt_ff      <= '0;
         force_ff         <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         rsp_frame_end_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         lo_ff            <= lo_in;
         hi_ff            <= hi_in;
         avail_ff         <= avail_in;
         build_word_ff    <= build_word_in;
         build_fill_ff    <= build_fill_in;
         entries_done_ff  <= entries_done_in;
         emit_cnt_ff      <= emit_cnt_in;
         force_ff         <= force_in;
         rsp_valid_ff     <= rsp_valid_in;
         rsp_frame_end_ff <= rsp_frame_end_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_packed_out_ff <= rsp_packed_out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_packed_out = rsp_packed_out_ff;
   assign rsp_frame_end  = rsp_frame_end_ff;

endmodule
`default_nettype wire

>>> tb/repack_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repack_checker
// Watches the input, result and register ports of the entry width repacker.
// It keeps its own copy of the width and count registers and of the frame
// state, works out the output words that every accepted input word causes,
// and compares each accepted output word with the oldest one still waiting.
// ----------------------------------------------------------------------------
module repack_checker #(
   parameter int MAX_ENTRIES = 4096
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_stall,
   input  wire logic [63:0]                         req_packed_in,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   input  wire logic [63:0]                         rsp_packed_out,
   input  wire logic                                rsp_frame_end,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic                                csr_pready,
   input  wire logic [pewr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [pewr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output int                                       error_count,
   output int                                       pending_count
);

   typedef struct packed {
      logic [pewr_pkg::WORD_BITS-1:0] word;
      logic                           frame_end;
   } out_word_type;

   logic [pewr_pkg::WIDTH_W-1:0]   in_width_reg;
   logic [pewr_pkg::WIDTH_W-1:0]   out_width_reg;
   logic [pewr_pkg::TOTAL_W-1:0]   entry_total_reg;

   logic [pewr_pkg::WORD_BITS-1:0] carry_bits;
   logic [pewr_pkg::WIDTH_W-1:0]   carry_count;
   logic [pewr_pkg::WORD_BITS-1:0] build_word;
   logic [pewr_pkg::WIDTH_W-1:0]   build_fill;
   logic [pewr_pkg::TOTAL_W-1:0]   entries_done;

   out_word_type                   expected_words[$];
   out_word_type                   oldest;

   initial begin
      error_count   = 0;
      pending_count = 0;
   end

   function automatic int unsigned effective_width(input logic [pewr_pkg::WIDTH_W-1:0] w);
      if (w == 0) return 1;
      if (w > pewr_pkg::WORD_BITS) return pewr_pkg::WORD_BITS;
      return 32'(w);
   endfunction

   function automatic logic [pewr_pkg::WORD_BITS-1:0] entry_mask(input int unsigned w);
      return (w >= pewr_pkg::WORD_BITS) ? '1 : ((64'd1 << w) - 64'd1);
   endfunction

   function automatic void clear_frame();
      carry_bits   = '0;
      carry_count  = '0;
      build_word   = '0;
      build_fill   = '0;
      entries_done = '0;
   endfunction

   function automatic void repack_word(input logic [pewr_pkg::WORD_BITS-1:0] word);
      int unsigned                    iw;
      int unsigned                    ow;
      int unsigned                    total;
      int unsigned                    cc;
      int unsigned                    avail;
      int unsigned                    f;
      int                             n;
      logic [pewr_pkg::WORD_BITS-1:0] imask;
      logic [pewr_pkg::WORD_BITS-1:0] omask;
      logic [pewr_pkg::WORD_BITS-1:0] lo;
      logic [pewr_pkg::WORD_BITS-1:0] hi;
      logic [pewr_pkg::WORD_BITS-1:0] v;
      logic                           frame_done;

      iw    = effective_width(in_width_reg);
      ow    = effective_width(out_width_reg);
      imask = entry_mask(iw);
      omask = entry_mask(ow);
      total = (entry_total_reg > MAX_ENTRIES) ? MAX_ENTRIES : 32'(entry_total_reg);
      n     = 0;

      // count dropped below progress: close the frame and drop the word
      if (entries_done != 0 && entries_done >= total) begin
         expected_words.push_back({build_word, 1'b1});
         clear_frame();
         return;
      end
      if (total == 0) return;

      cc    = 32'(carry_count[5:0]);
      lo    = carry_bits | (word << cc);
      hi    = (cc != 0) ? (word >> (pewr_pkg::WORD_BITS - cc)) : '0;
      avail = cc + pewr_pkg::WORD_BITS;

      while (avail >= iw && entries_done < total && n < 64) begin
         v = lo & imask;
         f = 32'(build_fill[5:0]);
         if (iw == pewr_pkg::WORD_BITS) begin
            lo = hi;
            hi = '0;
         end else begin
            lo = (lo >> iw) | (hi << (pewr_pkg::WORD_BITS - iw));
            hi = hi >> iw;
         end
         avail = avail - iw;
         v = v & omask;
         entries_done = entries_done + 1'b1;
         frame_done = (entries_done >= total);

         build_word = build_word | (v << f);
         if (f + ow >= pewr_pkg::WORD_BITS) begin
            expected_words.push_back({build_word,
                                      frame_done && (f + ow == pewr_pkg::WORD_BITS)});
            n++;
            build_word = (f != 0) ? (v >> (pewr_pkg::WORD_BITS - f)) : '0;
            build_fill = pewr_pkg::WIDTH_W'(f + ow - pewr_pkg::WORD_BITS);
         end else begin
            build_fill = pewr_pkg::WIDTH_W'(f + ow);
         end

         if (frame_done) begin
            if (build_fill > 0 && n < 64) begin
               expected_words.push_back({build_word, 1'b1});
            end
            clear_frame();
            return;
         end
      end

      carry_bits  = lo;
      carry_count = pewr_pkg::WIDTH_W'(avail);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         in_width_reg    = pewr_pkg::WIDTH_RESET;
         out_width_reg   = pewr_pkg::WIDTH_RESET;
         entry_total_reg = pewr_pkg::TOTAL_RESET;
         clear_frame();
         expected_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               error_count++;
               if (error_count <= 10) begin
                  $display("%0t: unexpected output word %h frame_end %b",
                           $realtime, rsp_packed_out, rsp_frame_end);
               end
            end else begin
               oldest = expected_words.pop_front();
               if (rsp_packed_out !== oldest.word || rsp_frame_end !== oldest.frame_end) begin
                  error_count++;
                  if (error_count <= 10) begin
                     $display("%0t: mismatch packed_out exp %h got %h, frame_end exp %b got %b",
                              $realtime, oldest.word, rsp_packed_out,
                              oldest.frame_end, rsp_frame_end);
                  end
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[pewr_pkg::CSR_ADDR_W-1:2])
               pewr_pkg::REG_IN_WIDTH:
                  in_width_reg    = csr_pwdata[pewr_pkg::WIDTH_W-1:0];
               pewr_pkg::REG_OUT_WIDTH:
                  out_width_reg   = csr_pwdata[pewr_pkg::WIDTH_W-1:0];
               pewr_pkg::REG_ENTRY_TOTAL:
                  entry_total_reg = csr_pwdata[pewr_pkg::TOTAL_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            repack_word(req_packed_in);
         end
      end
      pending_count = expected_words.size();
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the packed entry width repacker.
// A directed run over the width and count extremes, clamped register values,
// frames that end exactly on a word, mid word or after a lowered count, is
// followed by random frames with random widths, some broken off early. Both
// channels idle at random; the checker beside the block judges every word.
// ----------------------------------------------------------------------------
module tb;

   localparam int MAX_ENTRIES   = 4096;
   localparam int SETTLE_CYCLES = 100;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 200;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [63:0]                     req_packed_in;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [63:0]                     rsp_packed_out;
   logic                            rsp_frame_end;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [pewr_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [pewr_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [pewr_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   int                              error_count;
   int                              pending_count;
   int                              cycle_count;
   int                              req_idle_pct;
   int                              rsp_idle_pct;

   packed_entry_width_repacker_top #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_packed_in  (req_packed_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_packed_out (rsp_packed_out),
      .rsp_frame_end  (rsp_frame_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   repack_checker #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_packed_in  (req_packed_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_packed_out (rsp_packed_out),
      .rsp_frame_end  (rsp_frame_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_pready     (csr_pready),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   task automatic send_word(input logic [63:0] word);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_packed_in <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [pewr_pkg::REG_IDX_W-1:0]  idx,
                            input logic [pewr_pkg::CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   // drop valid, drain every expected word, then let the block go quiet
   task automatic settle();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure_frame(input logic [pewr_pkg::WIDTH_W-1:0] in_w,
                                  input logic [pewr_pkg::WIDTH_W-1:0] out_w,
                                  input logic [pewr_pkg::TOTAL_W-1:0] total);
      settle();
      csr_write(pewr_pkg::REG_IN_WIDTH, pewr_pkg::CSR_DATA_W'(in_w));
      csr_write(pewr_pkg::REG_OUT_WIDTH, pewr_pkg::CSR_DATA_W'(out_w));
      csr_write(pewr_pkg::REG_ENTRY_TOTAL, pewr_pkg::CSR_DATA_W'(total));
   endtask

   function automatic logic [pewr_pkg::WIDTH_W-1:0] pick_width();
      if ($urandom_range(9) == 0) begin
         return $urandom_range(1) ? 7'd0 : pewr_pkg::WIDTH_W'($urandom_range(65, 127));
      end
      return pewr_pkg::WIDTH_W'($urandom_range(1, 64));
   endfunction

   function automatic logic [63:0] pick_word();
      case ($urandom_range(15))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      logic [pewr_pkg::WIDTH_W-1:0] in_w;
      logic [pewr_pkg::WIDTH_W-1:0] out_w;
      logic [pewr_pkg::TOTAL_W-1:0] total;
      int                           eff_in;
      int                           frame_words;
      int                           word_count;
      int                           work_items;
      bit                           big_done;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_packed_in = '0;
      rsp_stall     = 1'b0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      cycle_count   = 0;
      req_idle_pct  = 16;
      rsp_idle_pct  = 49;
      work_items    = 0;
      big_done      = 0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty frame after reset: word ignored
      send_word(64'hDEAD_BEEF_0123_4567);
      // exact fill at frame end
      configure_frame(7'd8, 7'd8, 13'd8);
      send_word('1);
      send_word('0);
      // frame ends mid word, zero-extended entries
      configure_frame(7'd4, 7'd8, 13'd5);
      send_word(64'hFEDC_BA98_7654_3210);
      // straddling entries, truncated output
      configure_frame(7'd12, 7'd5, 13'd20);
      send_word(64'hAAAA_AAAA_AAAA_AAAA);
      send_word(64'h5555_5555_5555_5555);
      send_word(64'h0123_4567_89AB_CDEF);
      send_word('1);
      // clamped widths: zero acts as one, above 64 acts as 64
      configure_frame(7'd0, 7'd127, 13'd3);
      send_word(64'h8000_0000_0000_0005);
      configure_frame(7'd64, 7'd64, 13'd2);
      send_word(64'h8000_0000_0000_0001);
      send_word(64'h7FFF_FFFF_FFFF_FFFE);
      configure_frame(7'd100, 7'd0, 13'd3);
      send_word(64'h1);
      send_word(64'h0);
      send_word('1);
      configure_frame(7'd1, 7'd1, 13'd1);
      send_word('1);
      // count lowered below progress: flush and drop
      configure_frame(7'd8, 7'd3, 13'd100);
      send_word(64'hC3C3_C3C3_C3C3_C3C3);
      send_word(64'h3C3C_3C3C_3C3C_3C3C);
      configure_frame(7'd8, 7'd3, 13'd10);
      send_word(64'h1111_2222_3333_4444);
      configure_frame(7'd64, 7'd1, 13'd8191);
      send_word('1);
      configure_frame(7'd64, 7'd1, 13'd1);
      send_word('0);

      while (work_items < RANDOM_ITEMS) begin
         if (work_items < RANDOM_ITEMS / 3) begin
            req_idle_pct = 16;
            rsp_idle_pct = 49;
         end else if (work_items < 2 * RANDOM_ITEMS / 3) begin
            req_idle_pct = 49;
            rsp_idle_pct = 16;
         end else begin
            req_idle_pct = 0;
            rsp_idle_pct = 0;
         end
         in_w    = pick_width();
         out_w   = pick_width();
         eff_in  = (in_w == 0) ? 1 : ((in_w > 64) ? 64 : 32'(in_w));
         if (!big_done && work_items >= 20) begin
            // full-size frame: count register above the limit, 64 words out per word in
            big_done   = 1;
            in_w       = 7'd0;
            out_w      = 7'd64;
            total      = 13'd8191;
            word_count = MAX_ENTRIES / 64;
         end else if ($urandom_range(9) == 0) begin
            total      = 13'd0;
            word_count = 2;
         end else begin
            frame_words = $urandom_range(1, 6);
            total       = pewr_pkg::TOTAL_W'($urandom_range(1, frame_words * 64 / eff_in));
            frame_words = (32'(total) * eff_in + 63) / 64;
            word_count  = frame_words * $urandom_range(1, 3);
            if ($urandom_range(5) == 0 && word_count > 1) begin
               word_count = $urandom_range(1, word_count - 1);
            end
         end
         configure_frame(in_w, out_w, total);
         repeat (word_count) begin
            send_word(pick_word());
            work_items++;
         end
      end

      settle();
      if (error_count == 0 && pending_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
